@@ sv/crt_congruence_merger_macros.svh @@
// assertion helpers for the congruence merger checker
`ifndef CRT_CONGRUENCE_MERGER_MACROS_SVH
`define CRT_CONGRUENCE_MERGER_MACROS_SVH

// same-cycle implication under reset
`define CRTM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("crtm check failed");

// next-cycle implication under reset
`define CRTM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("crtm check failed");

`endif

@@ sv/crtm_pkg.sv @@
// ----------------------------------------------------------------------------
// crtm_pkg
// shared types and constants of the congruence merger
// ----------------------------------------------------------------------------
`default_nettype none
package crtm_pkg;
  localparam int WORD_WIDTH = 64;
  localparam logic [63:0] WORD_LIMIT = (64'd1 << (WORD_WIDTH - 1)) - 64'd1;
  localparam logic [63:0] NO_MOD     = {64{1'b1}};

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOSOL    = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_BADMOD   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RED, S_GDIV, S_GQM, S_GMUL, S_DM, S_DA, S_DL, S_ML,
    S_DMQ, S_DQ, S_DX, S_MK, S_MR, S_FIN
  } state_t;

  // one request to a shared unit
  typedef struct packed {
    logic        start;
    logic [63:0] op_a;
    logic [63:0] op_b;
    logic [63:0] op_m;
  } unit_req_t;
endpackage
`default_nettype wire

@@ sv/crt_congruence_merger.sv @@
// ----------------------------------------------------------------------------
// crt_congruence_merger
// merges congruences x = r (mod m) into a running solution
// ----------------------------------------------------------------------------
// A start word takes one division to reduce the residue. A merge word takes
// one reduction, then per extended gcd step one division of the remainders,
// one division of the quotient and one modular multiply (at most about 92
// steps), then six more divisions and three multiplies. All of them run on
// the shared bit-serial divider and multiplier. A word is taken only while
// the sequencer is idle; a bad modulus or a sticky status goes straight to
// the result state, a missing solution or an lcm overflow only after the gcd
// and the divisions that detect it.
`default_nettype none
module crt_congruence_merger (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [127:0] in_tdata,   // residue, modulus
  input  wire logic         in_tuser,   // first
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [127:0]      out_tdata   // solution, period, status
);
  import crtm_pkg::*;

  state_t      state_r, state_nxt;
  logic        go_r, go_nxt;
  logic [63:0] res_r, mod_r, acc_res_r, acc_res_nxt, acc_mod_r, acc_mod_nxt;
  status_t     fail_r, fail_nxt, rst_st_r, rst_st_nxt;
  logic        first_r, neg_r, neg_nxt;
  logic [63:0] r1_r, r1_nxt, ga_r, ga_nxt, gb_r, gb_nxt, s0_r, s0_nxt, s1_r, s1_nxt;
  logic [63:0] q_r, q_nxt, x_r, x_nxt, dq_r, dq_nxt, a_r, a_nxt, lcm_r, lcm_nxt;
  logic [63:0] mq_r, mq_nxt, sol_r, sol_nxt, per_r, per_nxt, t;
  logic        out_valid_r, out_valid_nxt;
  logic [127:0] out_data_r, out_data_nxt;
  unit_req_t   dreq, mreq;
  logic        ddone, mdone;
  logic [63:0] dquo, drem, mprod, mag, in_mod;
  logic        accept, in_mod_ok;

  crtm_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .done(ddone), .quo(dquo), .rem(drem));
  crtm_mulmod u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .done(mdone), .prod(mprod));

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign in_mod    = in_tdata[127:64];
  assign in_mod_ok = (in_mod != 64'd0) && (in_mod[63:WORD_WIDTH-1] == '0);
  assign mag       = res_r[63] ? 64'(64'd0 - res_r) : res_r;

  always_comb begin
    state_nxt   = state_r;
    go_nxt      = go_r;
    acc_res_nxt = acc_res_r;
    acc_mod_nxt = acc_mod_r;
    fail_nxt    = fail_r;
    rst_st_nxt  = rst_st_r;
    neg_nxt     = neg_r;
    r1_nxt = r1_r; ga_nxt = ga_r; gb_nxt = gb_r; s0_nxt = s0_r; s1_nxt = s1_r;
    q_nxt = q_r; x_nxt = x_r; dq_nxt = dq_r; a_nxt = a_r; lcm_nxt = lcm_r;
    mq_nxt = mq_r; sol_nxt = sol_r; per_nxt = per_r;
    t = 64'd0;
    dreq = '0;
    mreq = '0;
    mreq.op_m = NO_MOD;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          sol_nxt = 64'd0;
          per_nxt = 64'd0;
          if (in_tuser && !in_mod_ok) begin
            acc_res_nxt = 64'd0;
            acc_mod_nxt = 64'd1;
            fail_nxt    = ST_BADMOD;
            rst_st_nxt  = ST_BADMOD;
            state_nxt   = S_FIN;
          end else if (!in_tuser && fail_r != ST_OK) begin
            rst_st_nxt = fail_r;
            state_nxt  = S_FIN;
          end else if (!in_tuser && !in_mod_ok) begin
            fail_nxt   = ST_BADMOD;
            rst_st_nxt = ST_BADMOD;
            state_nxt  = S_FIN;
          end else begin
            state_nxt = S_RED;
          end
        end
      end
      S_RED: begin
        dreq.op_a = mag;
        dreq.op_b = mod_r;
        if (ddone) begin
          t = (res_r[63] && drem != 64'd0) ? 64'(mod_r - drem) : drem;
          r1_nxt = t;
          if (first_r) begin
            acc_res_nxt = t;
            acc_mod_nxt = mod_r;
            fail_nxt    = ST_OK;
            rst_st_nxt  = ST_OK;
            sol_nxt     = t;
            per_nxt     = mod_r;
            state_nxt   = S_FIN;
          end else begin
            ga_nxt    = acc_mod_r;
            gb_nxt    = mod_r;
            s0_nxt    = (mod_r == 64'd1) ? 64'd0 : 64'd1;
            s1_nxt    = 64'd0;
            state_nxt = S_GDIV;
          end
        end
      end
      S_GDIV: begin
        dreq.op_a = ga_r;
        dreq.op_b = gb_r;
        if (gb_r == 64'd0) begin
          state_nxt = S_DM;
        end else if (ddone) begin
          q_nxt     = dquo;
          ga_nxt    = gb_r;
          gb_nxt    = drem;
          state_nxt = S_GQM;
        end
      end
      S_GQM: begin
        dreq.op_a = q_r;
        dreq.op_b = mod_r;
        if (ddone) begin
          q_nxt     = drem;
          state_nxt = S_GMUL;
        end
      end
      S_GMUL: begin
        mreq.op_a = q_r;
        mreq.op_b = s1_r;
        mreq.op_m = mod_r;
        if (mdone) begin
          s0_nxt    = s1_r;
          s1_nxt    = (s0_r >= mprod) ? 64'(s0_r - mprod) : 64'(s0_r + (mod_r - mprod));
          state_nxt = S_GDIV;
        end
      end
      S_DM: begin
        // gcd in ga, coefficient in s0
        neg_nxt   = r1_r < acc_res_r;
        dreq.op_a = (r1_r < acc_res_r) ? 64'(acc_res_r - r1_r) : 64'(r1_r - acc_res_r);
        dreq.op_b = ga_r;
        x_nxt     = s0_r;
        if (ddone) begin
          dq_nxt = dquo;
          if (drem != 64'd0) begin
            fail_nxt   = ST_NOSOL;
            rst_st_nxt = ST_NOSOL;
            state_nxt  = S_FIN;
          end else begin
            state_nxt = S_DA;
          end
        end
      end
      S_DA: begin
        dreq.op_a = acc_mod_r;
        dreq.op_b = ga_r;
        if (ddone) begin
          a_nxt     = dquo;
          state_nxt = S_DL;
        end
      end
      S_DL: begin
        dreq.op_a = WORD_LIMIT;
        dreq.op_b = mod_r;
        if (ddone) begin
          if (a_r > dquo) begin
            fail_nxt   = ST_OVERFLOW;
            rst_st_nxt = ST_OVERFLOW;
            state_nxt  = S_FIN;
          end else begin
            state_nxt = S_ML;
          end
        end
      end
      S_ML: begin
        mreq.op_a = a_r;
        mreq.op_b = mod_r;
        if (mdone) begin
          lcm_nxt   = mprod;
          state_nxt = S_DMQ;
        end
      end
      S_DMQ: begin
        dreq.op_a = mod_r;
        dreq.op_b = ga_r;
        if (ddone) begin
          mq_nxt    = dquo;
          state_nxt = S_DQ;
        end
      end
      S_DQ: begin
        dreq.op_a = dq_r;
        dreq.op_b = mq_r;
        if (ddone) begin
          q_nxt     = (neg_r && drem != 64'd0) ? 64'(mq_r - drem) : drem;
          state_nxt = S_DX;
        end
      end
      S_DX: begin
        dreq.op_a = x_r;
        dreq.op_b = mq_r;
        if (ddone) begin
          x_nxt     = drem;
          state_nxt = S_MK;
        end
      end
      S_MK: begin
        mreq.op_a = q_r;
        mreq.op_b = x_r;
        mreq.op_m = mq_r;
        if (mdone) begin
          q_nxt     = mprod;
          state_nxt = S_MR;
        end
      end
      S_MR: begin
        mreq.op_a = acc_mod_r;
        mreq.op_b = q_r;
        if (mdone) begin
          t           = 64'(acc_res_r + mprod);
          acc_res_nxt = t;
          acc_mod_nxt = lcm_r;
          rst_st_nxt  = ST_OK;
          sol_nxt     = t;
          per_nxt     = lcm_r;
          state_nxt   = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {rst_st_r, per_r[62:0], sol_r[62:0]};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // one start pulse per unit operation
    dreq.start = 1'b0;
    mreq.start = 1'b0;
    if (state_nxt != state_r || ddone || mdone) begin
      go_nxt = 1'b0;
    end else begin
      case (state_r)
        S_RED, S_GQM, S_DM, S_DA, S_DL, S_DMQ, S_DQ, S_DX: begin
          dreq.start = !go_r;
          go_nxt     = 1'b1;
        end
        S_GDIV: begin
          dreq.start = !go_r && (gb_r != 64'd0);
          go_nxt     = 1'b1;
        end
        S_GMUL, S_ML, S_MK, S_MR: begin
          mreq.start = !go_r;
          go_nxt     = 1'b1;
        end
        default: go_nxt = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      go_r        <= 1'b0;
      acc_res_r   <= 64'd0;
      acc_mod_r   <= 64'd1;
      fail_r      <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      go_r        <= go_nxt;
      acc_res_r   <= acc_res_nxt;
      acc_mod_r   <= acc_mod_nxt;
      fail_r      <= fail_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (accept) begin
      res_r   <= in_tdata[63:0];
      mod_r   <= in_mod;
      first_r <= in_tuser;
    end
    rst_st_r <= rst_st_nxt;
    neg_r <= neg_nxt;
    r1_r <= r1_nxt; ga_r <= ga_nxt; gb_r <= gb_nxt; s0_r <= s0_nxt; s1_r <= s1_nxt;
    q_r <= q_nxt; x_r <= x_nxt; dq_r <= dq_nxt; a_r <= a_nxt; lcm_r <= lcm_nxt;
    mq_r <= mq_nxt; sol_r <= sol_nxt; per_r <= per_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
endmodule
`default_nettype wire

@@ sv/crtm_div.sv @@
// ----------------------------------------------------------------------------
// crtm_div
// restoring divider, one quotient bit per cycle, 64-bit operands
// ----------------------------------------------------------------------------
`default_nettype none
module crtm_div (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire crtm_pkg::unit_req_t req,
  output logic                     done,
  output logic [63:0]              quo,
  output logic [63:0]              rem
);
  import crtm_pkg::*;

  logic [127:0] rq_r, rq_nxt;
  logic [63:0]  d_r;
  logic [6:0]   cnt_r, cnt_nxt;
  logic         busy_r, busy_nxt, done_r, done_nxt;
  logic [64:0]  trial;

  always_comb begin
    trial    = {rq_r[127:63]};
    rq_nxt   = rq_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rq_nxt   = {64'd0, req.op_a};
      cnt_nxt  = 7'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, d_r}) begin
        rq_nxt = {trial[63:0] - d_r, rq_r[62:0], 1'b1};
      end else begin
        rq_nxt = {trial[63:0], rq_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 7'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rq_r <= rq_nxt;
    if (req.start) d_r <= req.op_b;
  end

  assign done = done_r;
  assign quo  = rq_r[63:0];
  assign rem  = rq_r[127:64];
endmodule
`default_nettype wire

@@ sv/crtm_mulmod.sv @@
// ----------------------------------------------------------------------------
// crtm_mulmod
// shift-add modular multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module crtm_mulmod (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire crtm_pkg::unit_req_t req,
  output logic                     done,
  output logic [63:0]              prod
);
  import crtm_pkg::*;

  logic [63:0] a_r, a_nxt, b_r, b_nxt, acc_r, acc_nxt, m_r;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [64:0] s_acc, s_dbl;

  // with modulus all ones this is a plain product while the product stays below it
  always_comb begin
    s_acc    = {1'b0, acc_r} + {1'b0, a_r};
    s_dbl    = {1'b0, a_r} + {1'b0, a_r};
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      a_nxt    = req.op_a;
      b_nxt    = req.op_b;
      acc_nxt  = 64'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (b_r == 64'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        if (b_r[0]) begin
          acc_nxt = (s_acc >= {1'b0, m_r}) ? 64'(s_acc - {1'b0, m_r}) : s_acc[63:0];
        end
        a_nxt = (s_dbl >= {1'b0, m_r}) ? 64'(s_dbl - {1'b0, m_r}) : s_dbl[63:0];
        b_nxt = {1'b0, b_r[63:1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
    if (req.start) m_r <= req.op_m;
  end

  assign done = done_r;
  assign prod = acc_r;
endmodule
`default_nettype wire

@@ sv/crtm_checker.sv @@
// ----------------------------------------------------------------------------
// crtm_checker
// port-level checks of the congruence merger
// ----------------------------------------------------------------------------
`default_nettype none
`include "crt_congruence_merger_macros.svh"
module crtm_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [127:0] out_tdata
);
  // a failed word carries no solution or period
  `CRTM_ASSERT_NOW(fail_zero, out_tvalid && out_tdata[127:126] != 2'd0, out_tdata[125:0] == 126'd0)
  // a good word has solution below period
  `CRTM_ASSERT_NOW(ok_range, out_tvalid && out_tdata[127:126] == 2'd0, out_tdata[62:0] < out_tdata[125:63])
  // a taken word leaves the merger busy in the following cycle
  `CRTM_ASSERT_NEXT(busy_after, in_tvalid && in_tready, !in_tready)
  // a stalled result holds
  `CRTM_ASSERT_NEXT(out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
endmodule

bind crt_congruence_merger crtm_checker u_crtm_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
`default_nettype wire

@@ tb/crt_congruence_merger_tb.sv @@
// ----------------------------------------------------------------------------
// crt_congruence_merger_tb
// self-checking bench for the congruence merger: a directed table with typed
// results for the easy rows, then random systems of congruences in phases
// with different idle and stall rates; every untyped result is compared with
// an in-bench predictor of the merge
// ----------------------------------------------------------------------------
`default_nettype none
module crt_congruence_merger_tb;
  import crtm_pkg::*;

  localparam logic [63:0] MAX_POS = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] MIN_NEG = 64'h8000_0000_0000_0000;
  localparam int END_DRAIN = 100;

  typedef struct packed {
    logic [62:0] solution;
    logic [62:0] period;
    status_t     status;
  } merge_result_t;

  typedef struct {
    logic [63:0]   residue;
    logic [63:0]   modulus;
    logic          first;
    logic          typed;
    merge_result_t want;
  } table_row_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;
  logic         in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [127:0] out_tdata;

  crt_congruence_merger uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // predictor state: the combined congruence and the sticky failure
  logic [63:0]   sys_residue;
  logic [63:0]   sys_modulus;
  status_t       sys_fail;

  merge_result_t pending_q[$];
  int            errors;
  int            words_sent;
  int            words_checked;
  int            status_seen[4];
  int            send_idle_pct;
  int            recv_stall_pct;
  int            hold_request;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // ---------------- predictor ----------------
  function automatic logic [63:0] fold_signed(logic [63:0] v, logic [63:0] m);
    logic [63:0] rem;
    if (!v[63]) return v % m;
    rem = (64'd0 - v) % m;
    return (rem == 0) ? 64'd0 : m - rem;
  endfunction

  function automatic logic [63:0] mul_mod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return 64'(p % {64'd0, m});
  endfunction

  // returns gcd(a, b); inv gets the bezout coefficient of a, reduced mod b
  function automatic logic [63:0] gcd_bezout(logic [63:0] a, logic [63:0] b,
                                            output logic [63:0] inv);
    logic [63:0] ra, rb, sa, sb, q, t;
    ra = a; rb = b; sa = 64'd1 % b; sb = 64'd0;
    while (rb != 0) begin
      q = ra / rb;
      t = ra - q * rb;
      ra = rb;
      rb = t;
      t = mul_mod(q % b, sb, b);
      t = (sa >= t) ? sa - t : sa + (b - t);
      sa = sb;
      sb = t;
    end
    inv = sa;
    return ra;
  endfunction

  function automatic merge_result_t merge_word(logic [63:0] res, logic [63:0] m, logic first);
    merge_result_t o;
    logic [63:0] m0, r0, r1, g, inv, diff, q, mq, k, a;
    logic        mod_ok, neg;
    o = '{63'd0, 63'd0, ST_OK};
    mod_ok = !m[63] && (m != 0);
    if (first) begin
      if (!mod_ok) begin
        sys_residue = 0; sys_modulus = 1; sys_fail = ST_BADMOD;
        o.status = ST_BADMOD;
        return o;
      end
      sys_fail = ST_OK;
      sys_modulus = m;
      sys_residue = fold_signed(res, m);
      o.solution = sys_residue[62:0];
      o.period = sys_modulus[62:0];
      return o;
    end
    if (sys_fail != ST_OK) begin
      o.status = sys_fail;
      return o;
    end
    if (!mod_ok) begin
      sys_fail = ST_BADMOD;
      o.status = sys_fail;
      return o;
    end
    m0 = sys_modulus;
    r0 = sys_residue % m0;
    r1 = fold_signed(res, m);
    g = gcd_bezout(m0, m, inv);
    neg = r1 < r0;
    diff = neg ? r0 - r1 : r1 - r0;
    if (diff % g != 0) begin
      sys_fail = ST_NOSOL;
      o.status = sys_fail;
      return o;
    end
    a = m0 / g;
    if (a > MAX_POS / m) begin
      sys_fail = ST_OVERFLOW;
      o.status = sys_fail;
      return o;
    end
    mq = m / g;
    q = (diff / g) % mq;
    if (neg && q != 0) q = mq - q;
    k = mul_mod(q, inv % mq, mq);
    sys_residue = r0 + m0 * k;
    sys_modulus = a * m;
    o.solution = sys_residue[62:0];
    o.period = sys_modulus[62:0];
    return o;
  endfunction

  // ---------------- input side ----------------
  task automatic send_word(logic [63:0] res, logic [63:0] m, logic first,
                           logic typed, merge_result_t want);
    merge_result_t got;
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {m, res};
    in_tuser  <= first;
    do @(posedge clk); while (!in_tready);
    got = merge_word(res, m, first);
    pending_q.push_back(typed ? want : got);
    words_sent++;
    gap = 0;
    if ($urandom_range(99) < send_idle_pct) gap = $urandom_range(1, 40);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    wait (pending_q.size() == 0);
    repeat (END_DRAIN) @(posedge clk);
  endtask

  // ---------------- output side ----------------
  always @(posedge clk) begin
    merge_result_t got, want;
    int hold_left;
    if (rst_n && out_tvalid && out_tready) begin
      got.solution = out_tdata[62:0];
      got.period   = out_tdata[125:63];
      got.status   = status_t'(out_tdata[127:126]);
      if (pending_q.size() == 0) begin
        $error("result word with nothing pending: %h", out_tdata);
        errors++;
      end else begin
        want = pending_q.pop_front();
        words_checked++;
        status_seen[got.status]++;
        if (got.solution !== want.solution) begin
          $error("solution: expected %0d, got %0d", want.solution, got.solution);
          errors++;
        end
        if (got.period !== want.period) begin
          $error("period: expected %0d, got %0d", want.period, got.period);
          errors++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %s, got %s", want.status.name(), got.status.name());
          errors++;
        end
      end
    end
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------- stimulus ----------------
  table_row_t dir_rows[$];

  function automatic table_row_t row(logic [63:0] r, logic [63:0] m, logic f,
                                     logic typed = 0, logic [62:0] s = 0,
                                     logic [62:0] p = 0, status_t st = ST_OK);
    table_row_t t;
    t.residue = r; t.modulus = m; t.first = f; t.typed = typed;
    t.want = '{s, p, st};
    return t;
  endfunction

  task automatic random_phase(int count);
    logic [63:0] secret, m, r, rm;
    int left, roll;
    logic big, first;
    left = 0; big = 0; secret = 0;
    for (int n = 0; n < count; n++) begin
      first = 1'b0;
      if (left == 0) begin
        left = $urandom_range(2, 8);
        big = ($urandom_range(99) < 6);
        secret = {$urandom, $urandom};
        if (!big) secret = secret % 64'd100000;
        first = 1'b1;
      end
      left--;
      if (big) m = {1'b0, 31'($urandom), 32'($urandom)};
      else m = 64'($urandom_range(1, 60));
      if (m == 0) m = 1;
      rm = secret % m;
      if (m < 64'd1000) r = rm + m * 64'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
      else r = $urandom_range(1) ? rm - m : rm;
      roll = $urandom_range(99);
      if (roll < 4) m = $urandom_range(1) ? 64'd0 : {1'b1, 31'($urandom), 32'($urandom)};
      else if (roll < 10) r = {$urandom, $urandom};
      send_word(r, m, first, 1'b0, '0);
    end
  endtask

  initial begin
    errors = 0; words_sent = 0; words_checked = 0;
    hold_request = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    for (int i = 0; i < 4; i++) status_seen[i] = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    out_tready = 1'b0;
    sys_residue = 0; sys_modulus = 1; sys_fail = ST_OK;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // merge into the reset state acts as a start
    dir_rows.push_back(row(64'd5, 64'd7, 0, 1, 5, 7, ST_OK));
    dir_rows.push_back(row(-64'd1, 64'd10, 1, 1, 9, 10, ST_OK));
    dir_rows.push_back(row(64'd3, 64'd4, 0, 1, 19, 20, ST_OK));
    dir_rows.push_back(row(64'd0, 64'd6, 0, 1, 0, 0, ST_NOSOL));
    dir_rows.push_back(row(64'd1, 64'd3, 0, 1, 0, 0, ST_NOSOL));
    dir_rows.push_back(row(MIN_NEG, MAX_POS, 1));
    dir_rows.push_back(row(64'd1, 64'd2, 0, 1, 0, 0, ST_OVERFLOW));
    dir_rows.push_back(row(64'd1, 64'd5, 0, 1, 0, 0, ST_OVERFLOW));
    dir_rows.push_back(row(64'd4, 64'd0, 1, 1, 0, 0, ST_BADMOD));
    dir_rows.push_back(row(64'd4, 64'd9, 0, 1, 0, 0, ST_BADMOD));
    dir_rows.push_back(row(MAX_POS, 64'd3, 1));
    dir_rows.push_back(row(64'd2, -64'd5, 0, 1, 0, 0, ST_BADMOD));
    dir_rows.push_back(row(64'd7, 64'd1, 1, 1, 0, 1, ST_OK));
    dir_rows.push_back(row(MIN_NEG, 64'd1, 0, 1, 0, 1, ST_OK));
    dir_rows.push_back(row(64'd0, MIN_NEG, 1, 1, 0, 0, ST_BADMOD));
    dir_rows.push_back(row(64'd0, -64'd1, 1, 1, 0, 0, ST_BADMOD));
    dir_rows.push_back(row(64'd1, MAX_POS, 1));
    dir_rows.push_back(row(MAX_POS, MAX_POS, 0));
    dir_rows.push_back(row(-64'd3, 64'd12, 1));
    dir_rows.push_back(row(64'd9, 64'd18, 0));
    dir_rows.push_back(row(64'd5, 64'd35, 0));
    dir_rows.push_back(row(MIN_NEG, 64'h4000_0000_0000_0000, 1));
    dir_rows.push_back(row(64'd0, 64'd3, 0));
    foreach (dir_rows[i])
      send_word(dir_rows[i].residue, dir_rows[i].modulus, dir_rows[i].first,
                dir_rows[i].typed, dir_rows[i].want);
    drain_results();

    // long receiver hold while the sender keeps offering words
    send_idle_pct = 0; recv_stall_pct = 0;
    hold_request = 4000;
    random_phase(190);
    drain_results();
    send_idle_pct = 57; recv_stall_pct = 0;
    random_phase(180);
    drain_results();
    send_idle_pct = 0; recv_stall_pct = 57;
    random_phase(180);
    drain_results();
    send_idle_pct = 13; recv_stall_pct = 13;
    random_phase(180);
    drain_results();

    $display("covered %0d words, %0d results checked", words_sent, words_checked);
    $display("statuses seen: ok %0d, no solution %0d, overflow %0d, bad modulus %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #1_000_000_000;
    $display("timeout with %0d results pending", pending_q.size());
    $display("Simulation FAILED");
    $finish;
  end
endmodule
`default_nettype wire
